// ===== rtl/k_way_sorted_merge_assert.svh =====
// Assertion macros used by the checker file of the sorted merge block.
`ifndef K_WAY_SORTED_MERGE_ASSERT_SVH
`define K_WAY_SORTED_MERGE_ASSERT_SVH
// Asserts that an antecedent implies a consequent in the same cycle.
`define KWM_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// Asserts that an antecedent implies a consequent in the following cycle.
`define KWM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

// ===== rtl/kwm_pkg.sv =====
// Package with types and constants of the sorted merge block.
`default_nettype none
package kwm_pkg;
    localparam int NUM_LISTS  = 8;
    localparam int LIST_DEPTH = 64;
    localparam int LW = $clog2(NUM_LISTS);
    localparam int PW = $clog2(LIST_DEPTH);
    localparam int CW = $clog2(LIST_DEPTH + 1);
    localparam int QDEPTH = 2;

    localparam logic [1:0] ST_APPENDED = 2'd0;
    localparam logic [1:0] ST_FULL     = 2'd1;
    localparam logic [1:0] ST_POPPED   = 2'd2;
    localparam logic [1:0] ST_EMPTY    = 2'd3;

    localparam logic CMD_APPEND = 1'b0;
    localparam logic CMD_POP    = 1'b1;

    typedef struct packed {
        logic        cmd;
        logic [2:0]  list_index;
        logic [31:0] value;
    } item_t;
endpackage
`default_nettype wire

// ===== rtl/k_way_sorted_merge.sv =====
// Top level of the K-way sorted merge block.
// An append answers in the cycle after its transfer leaves the queue.
// Appends go one per cycle unless the output is held; a pop that refills a head
// holds off new items through the registered read of the list store and the head register load.
// Reset: asynchronous and active low; clears pointers, counts and queue.
// The list store has no reset; only written entries are ever loaded into a head.
`default_nettype none
module k_way_sorted_merge (
    input  wire         clk,
    input  wire         rst_n,
    input  wire         in_valid,
    output logic        in_ready,
    input  wire         cmd,
    input  wire  [2:0]  list_index,
    input  wire  [31:0] value,
    output logic        out_valid,
    input  wire         out_ready,
    output logic [1:0]  status,
    output logic [31:0] merged_value,
    output logic [2:0]  from_list
);
    import kwm_pkg::*;

    // The front queue holds each transfer until the back end is free.
    item_t in_item, q_item;
    logic  q_valid, q_ready;

    assign in_item = '{cmd: cmd, list_index: list_index, value: value};

    kwm_front u_front (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .in_item(in_item),
        .q_valid(q_valid), .q_ready(q_ready), .q_item(q_item)
    );

    // The back end executes one item and registers its result.
    kwm_back u_back (
        .clk(clk), .rst_n(rst_n),
        .q_valid(q_valid), .q_ready(q_ready), .q_item(q_item),
        .out_valid(out_valid), .out_ready(out_ready),
        .status(status), .merged_value(merged_value), .from_list(from_list)
    );
endmodule
`default_nettype wire

// ===== rtl/kwm_front.sv =====
// Front end: input skid queue that decouples acceptance from execution.
`default_nettype none
module kwm_front (
    input  wire            clk,
    input  wire            rst_n,
    input  wire            in_valid,
    output logic           in_ready,
    input  kwm_pkg::item_t in_item,
    output logic           q_valid,
    input  wire            q_ready,
    output kwm_pkg::item_t q_item
);
    import kwm_pkg::*;

    item_t      mem_reg [QDEPTH];
    logic       wp_reg, wp_next, rp_reg, rp_next;
    logic [1:0] cnt_reg, cnt_next;
    logic       push, pop;

    assign in_ready = (cnt_reg != 2'(QDEPTH));
    assign q_valid  = (cnt_reg != 2'd0);
    assign q_item   = mem_reg[rp_reg];
    assign push     = in_valid && in_ready;
    assign pop      = q_valid && q_ready;

    always_comb
    begin
        wp_next  = push ? ~wp_reg : wp_reg;
        rp_next  = pop ? ~rp_reg : rp_reg;
        cnt_next = cnt_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wp_reg] <= in_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
    end
endmodule
`default_nettype wire

// ===== rtl/kwm_back.sv =====
// Back end: list store, head registers, minimum search and result register.
`default_nettype none
module kwm_back (
    input  wire            clk,
    input  wire            rst_n,
    input  wire            q_valid,
    output logic           q_ready,
    input  kwm_pkg::item_t q_item,
    output logic           out_valid,
    input  wire            out_ready,
    output logic [1:0]     status,
    output logic [31:0]    merged_value,
    output logic [2:0]     from_list
);
    import kwm_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE   = 3'b001,
        S_REFILL = 3'b010,
        S_LOAD   = 3'b100
    } state_t;

    logic [31:0] store [NUM_LISTS*LIST_DEPTH];
    logic [31:0] rdata_reg;
    logic [31:0] head_reg [NUM_LISTS];
    logic [PW-1:0] rptr_reg [NUM_LISTS];
    logic [PW-1:0] wptr_reg [NUM_LISTS];
    logic [CW-1:0] fill_reg [NUM_LISTS];
    state_t        state_reg, state_next;
    logic [LW-1:0] tgt_reg;
    logic          ovalid_reg;
    logic [1:0]    st_reg;
    logic [31:0]   mv_reg;
    logic [2:0]    fl_reg;

    // Minimum search: lowest index wins ties.
    logic          found;
    logic [LW-1:0] best;
    logic [31:0]   best_v;
    always_comb
    begin
        found  = 1'b0;
        best   = '0;
        best_v = '0;
        for (int k = 0; k < NUM_LISTS; k++)
        begin
            if (fill_reg[k] != '0 &&
                (!found || $signed(head_reg[k]) < $signed(best_v)))
            begin
                found  = 1'b1;
                best   = LW'(k);
                best_v = head_reg[k];
            end
        end
    end

    logic          li_ok, full, exec;
    logic [LW-1:0] li;
    assign li      = q_item.list_index[LW-1:0];
    assign li_ok   = ({29'd0, q_item.list_index} < 32'(NUM_LISTS));
    assign full    = !li_ok || fill_reg[li] == CW'(LIST_DEPTH);
    assign q_ready = (state_reg == S_IDLE) && (!ovalid_reg || out_ready);
    assign exec    = q_valid && q_ready;

    logic [PW-1:0] nrp;
    assign nrp = rptr_reg[best] + PW'(1);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
                if (exec && q_item.cmd == CMD_POP && found && fill_reg[best] > CW'(1))
                    state_next = S_REFILL;
            S_REFILL: state_next = S_LOAD;
            S_LOAD:   state_next = S_IDLE;
            default:  state_next = S_IDLE;
        endcase
    end

    // Memory: one write port for appends, one registered read for refills.
    always_ff @(posedge clk)
    begin
        if (exec && q_item.cmd == CMD_APPEND && !full)
            store[{li, wptr_reg[li]}] <= q_item.value;
        rdata_reg <= store[{tgt_reg, rptr_reg[tgt_reg]}];
    end

    always_ff @(posedge clk)
    begin
        if (exec && q_item.cmd == CMD_APPEND && !full && fill_reg[li] == '0)
            head_reg[li] <= q_item.value;
        if (state_reg == S_LOAD)
            head_reg[tgt_reg] <= rdata_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            tgt_reg    <= '0;
            ovalid_reg <= 1'b0;
            st_reg     <= ST_APPENDED;
            mv_reg     <= '0;
            fl_reg     <= '0;
            for (int k = 0; k < NUM_LISTS; k++)
            begin
                rptr_reg[k] <= '0;
                wptr_reg[k] <= '0;
                fill_reg[k] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            if (out_valid && out_ready)
                ovalid_reg <= 1'b0;
            if (exec)
            begin
                ovalid_reg <= 1'b1;
                mv_reg     <= '0;
                fl_reg     <= '0;
                if (q_item.cmd == CMD_APPEND)
                begin
                    if (full)
                        st_reg <= ST_FULL;
                    else
                    begin
                        st_reg       <= ST_APPENDED;
                        wptr_reg[li] <= wptr_reg[li] + PW'(1);
                        fill_reg[li] <= fill_reg[li] + CW'(1);
                    end
                end
                else if (!found)
                    st_reg <= ST_EMPTY;
                else
                begin
                    st_reg         <= ST_POPPED;
                    mv_reg         <= best_v;
                    fl_reg         <= 3'({{(32-LW){1'b0}}, best});
                    rptr_reg[best] <= nrp;
                    fill_reg[best] <= fill_reg[best] - CW'(1);
                    tgt_reg        <= best;
                end
            end
        end
    end

    assign out_valid    = ovalid_reg;
    assign status       = st_reg;
    assign merged_value = mv_reg;
    assign from_list    = fl_reg;
endmodule
`default_nettype wire

// ===== rtl/kwm_checker.sv =====
// Port-level checker for the sorted merge block and its bind.
`default_nettype none
`include "k_way_sorted_merge_assert.svh"
module kwm_checker (
    input wire        clk,
    input wire        rst_n,
    input wire        out_valid,
    input wire        out_ready,
    input wire [1:0]  status,
    input wire [31:0] merged_value,
    input wire [2:0]  from_list
);
    import kwm_pkg::*;
    `KWM_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(status))
    `KWM_ASSERT_IMP(a_zero_val, clk, rst_n, out_valid && status != ST_POPPED, merged_value == 32'd0)
    `KWM_ASSERT_IMP(a_zero_list, clk, rst_n, out_valid && status != ST_POPPED, from_list == 3'd0)
endmodule
bind k_way_sorted_merge kwm_checker u_checker (.*);
`default_nettype wire
